// ===== hdl/hprb_pkg.sv =====
// Package for the heap packet reorder buffer.
// Holds depth constants, field widths, action and kind codes and the sequencer state type.
package hprb_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RUN_LIMIT = 64;
    localparam int RW = $clog2(RUN_LIMIT + 1);
    localparam int EW = 32;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_END = 1'b1;
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WAIT,
        ST_INS_CMP,
        ST_CHK_RD,
        ST_CHK_WAIT,
        ST_CHK_TEST,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_OUT,
        ST_POP_DONE
    } state_t;
endpackage

// ===== hdl/hprb_ram.sv =====
// Generic single-port-write, one-read-port RAM with registered read.
// No dependencies.
module hprb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/heap_packet_reorder_buffer.sv =====
// Heap packet reorder buffer: min-heap on sequence numbers in one RAM.
// Insert sifts up, release pops and sifts down, one read per cycle.
// Insert walks up one level at a time; each pop reads the root, refills it from the last
//   entry, sifts down level by level and then hands the result to the output handshake.
// One item at a time; in_stall is high while the sequencer is busy or a result waits.
// Reset (async, active low): heap empty, batch, expected-sequence and group counters zero, batch_size 1.
module heap_packet_reorder_buffer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [15:0] seq_number,
    input  logic [15:0] payload_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [15:0] out_seq,
    output logic [15:0] out_tag,
    output logic [15:0] out_group,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import hprb_pkg::*;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0] batch_reg, batch_next;
    logic [6:0] bsize_reg;
    logic [15:0] nexp_reg, nexp_next;
    logic [15:0] group_reg, group_next;
    logic [RW-1:0] run_reg, run_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] mi_reg, mi_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [EW-1:0] best_reg, best_next;
    logic ov_reg, ov_next;
    logic ok_reg, ok_next;
    logic [EW-1:0] oe_reg, oe_next;
    logic olast_reg, olast_next;
    logic pend_reg, pend_next;
    logic hold_reg, hold_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [AW:0] lch, rch;
    logic [AW-1:0] par;
    logic hit;

    hprb_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram
    (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_kind = ok_reg;
    assign out_seq = oe_reg[31:16];
    assign out_tag = oe_reg[15:0];
    assign out_group = group_reg;
    assign last_of_run = olast_reg;

    assign lch = {idx_reg, 1'b1};
    assign rch = {idx_reg, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
    assign par = AW'(({1'b0, idx_reg} - {{AW{1'b0}}, 1'b1}) >> 1);
    assign hit = (count_reg != '0) && (run_reg != RW'(RUN_LIMIT)) &&
                 (rdata[31:16] == nexp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            batch_reg <= '0;
            bsize_reg <= 7'd1;
            nexp_reg <= '0;
            group_reg <= '0;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            batch_reg <= batch_next;
            nexp_reg <= nexp_next;
            group_reg <= group_next;
            ov_reg <= ov_next;
            pend_reg <= pend_next;
            hold_reg <= hold_next;
            if (cfg_valid && cfg_ready)
            begin
                bsize_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        idx_reg <= idx_next;
        mi_reg <= mi_next;
        cur_reg <= cur_next;
        best_reg <= best_next;
        ok_reg <= ok_next;
        oe_reg <= oe_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        batch_next = batch_reg;
        nexp_next = nexp_reg;
        group_next = group_reg;
        run_next = run_reg;
        idx_next = idx_reg;
        mi_next = mi_reg;
        cur_next = cur_reg;
        best_next = best_reg;
        ov_next = ov_reg;
        ok_next = ok_reg;
        oe_next = oe_reg;
        olast_next = olast_reg;
        pend_next = pend_reg;
        hold_next = hold_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = cur_reg;
        raddr = idx_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
            if (pend_reg)
            begin
                pend_next = 1'b0;
                group_next = group_reg + 16'd1;
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    run_next = '0;
                    if (action == ACT_END)
                    begin
                        batch_next = '0;
                        state_next = ST_CHK_RD;
                    end
                    else if (count_reg >= CW'(DEPTH))
                    begin
                        ov_next = 1'b1;
                        ok_next = KIND_DROP;
                        oe_next = {seq_number, payload_tag};
                        olast_next = 1'b1;
                    end
                    else
                    begin
                        cur_next = {seq_number, payload_tag};
                        idx_next = AW'(count_reg);
                        count_next = count_reg + CW'(1);
                        batch_next = batch_reg + 7'd1;
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                we = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_CHK_RD;
                end
                else
                begin
                    raddr = par;
                    state_next = ST_INS_WAIT;
                end
            end
            ST_INS_WAIT:
            begin
                raddr = par;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (rdata[31:16] > cur_reg[31:16])
                begin
                    we = 1'b1;
                    wdata = rdata;
                    idx_next = par;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD:
            begin
                if (batch_reg != '0 && batch_reg < bsize_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    batch_next = '0;
                    raddr = '0;
                    state_next = ST_CHK_WAIT;
                end
            end
            ST_CHK_WAIT:
            begin
                raddr = '0;
                state_next = ST_CHK_TEST;
            end
            ST_CHK_TEST:
            begin
                if (!ov_reg)
                begin
                    if (hold_reg)
                    begin
                        hold_next = 1'b0;
                        ov_next = 1'b1;
                        ok_next = KIND_RELEASE;
                        olast_next = !hit;
                        pend_next = !hit;
                        raddr = '0;
                        if (hit)
                        begin
                            state_next = ST_CHK_WAIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (hit)
                    begin
                        oe_next = rdata;
                        count_next = count_reg - CW'(1);
                        state_next = ST_POP_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    raddr = '0;
                    state_next = ST_CHK_WAIT;
                end
            end
            ST_POP_RD:
            begin
                raddr = AW'(count_reg);
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT:
            begin
                cur_next = rdata;
                idx_next = '0;
                state_next = ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                mi_next = idx_reg;
                best_next = cur_reg;
                if (lch < (AW+1)'(count_reg))
                begin
                    raddr = AW'(lch);
                    state_next = ST_DN_RDR;
                end
                else
                begin
                    we = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_DN_RDR:
            begin
                raddr = AW'(rch);
                state_next = ST_DN_CMP;
                if (rdata[31:16] < best_reg[31:16])
                begin
                    best_next = rdata;
                    mi_next = AW'(lch);
                end
            end
            ST_DN_CMP:
            begin
                if (rch < (AW+1)'(count_reg) && rdata[31:16] < best_reg[31:16])
                begin
                    best_next = rdata;
                    mi_next = AW'(rch);
                end
                state_next = ST_POP_DONE;
            end
            ST_POP_DONE:
            begin
                if (mi_reg == idx_reg)
                begin
                    we = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    we = 1'b1;
                    wdata = best_reg;
                    idx_next = mi_reg;
                    state_next = ST_DN_RDL;
                end
            end
            ST_OUT:
            begin
                hold_next = 1'b1;
                nexp_next = nexp_reg + 16'd1;
                run_next = run_reg + RW'(1);
                raddr = '0;
                state_next = ST_CHK_WAIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ST_CHK_TEST drives last flag on a held output; finalize it there
    // by holding the last release until the check decides.

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("heap count over depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !(state_reg == ST_IDLE && $past(action) == ACT_END
            && $past(state_reg) == ST_IDLE && !$past(ov_reg)) || ov_reg)
    else $error("end transaction not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg && $stable(oe_reg))
    else $error("result lost under stall");
endmodule

// ===== tb/tb_heap_packet_reorder_buffer.sv =====
// Testbench for the heap packet reorder buffer: drives packets and end items,
// predicts releases and drops with a min-heap model and checks each result.
// Depends on hprb_pkg and the heap_packet_reorder_buffer RTL.
`timescale 1ns / 100ps

module tb_heap_packet_reorder_buffer;
    import hprb_pkg::*;

    typedef struct packed {
        logic        act;
        logic [15:0] seq;
        logic [15:0] tag;
    } pkt_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] seq;
        logic [15:0] tag;
        logic [15:0] grp;
        logic        last;
    } rel_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [15:0] seq_number;
    logic [15:0] payload_tag;
    logic        out_valid;
    logic        out_stall;
    logic        out_kind;
    logic [15:0] out_seq;
    logic [15:0] out_tag;
    logic [15:0] out_group;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    pkt_t        pending_q[$];
    rel_t        expected_q[$];
    logic [31:0] heap_m[DEPTH];
    int          heap_n;
    int          batch_n;
    logic [15:0] next_seq;
    logic [15:0] group_n;
    logic [6:0]  batch_lim;
    int          errors;
    int          n_release;
    int          n_drop;
    int          n_sent;
    int          cycles;
    bit          calm;
    bit          sent_flag;
    logic [15:0] next_free;

    heap_packet_reorder_buffer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .seq_number(seq_number), .payload_tag(payload_tag),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_kind(out_kind), .out_seq(out_seq), .out_tag(out_tag),
        .out_group(out_group), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [15:0] key(input logic [31:0] e);
        return e[31:16];
    endfunction

    task automatic heap_push(input logic [31:0] e);
        int i;
        int p;
        logic [31:0] t;
        i = heap_n;
        heap_m[i] = e;
        heap_n++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (key(heap_m[p]) > key(heap_m[i]))
            begin
                t = heap_m[p];
                heap_m[p] = heap_m[i];
                heap_m[i] = t;
                i = p;
            end
            else
                break;
        end
    endtask

    task automatic heap_take();
        int i;
        int m;
        int l;
        int r;
        logic [31:0] t;
        i = 0;
        heap_n--;
        heap_m[0] = heap_m[heap_n];
        forever
        begin
            m = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_n && key(heap_m[l]) < key(heap_m[m])) m = l;
            if (r < heap_n && key(heap_m[r]) < key(heap_m[m])) m = r;
            if (m == i) break;
            t = heap_m[m];
            heap_m[m] = heap_m[i];
            heap_m[i] = t;
            i = m;
        end
    endtask

    task automatic release_in_order();
        int k;
        k = 0;
        while (k < RUN_LIMIT && heap_n > 0 && key(heap_m[0]) == next_seq)
        begin
            expected_q.push_back({KIND_RELEASE, heap_m[0], group_n, 1'b0});
            heap_take();
            next_seq++;
            k++;
        end
        if (k > 0)
        begin
            expected_q[$].last = 1'b1;
            group_n++;
        end
    endtask

    task automatic predict_reorder(input pkt_t p);
        if (p.act == ACT_END)
        begin
            batch_n = 0;
            release_in_order();
        end
        else if (heap_n >= DEPTH)
            expected_q.push_back({KIND_DROP, p.seq, p.tag, group_n, 1'b1});
        else
        begin
            heap_push({p.seq, p.tag});
            batch_n = (batch_n + 1) & 7'h7f;
            if (batch_n >= batch_lim)
            begin
                batch_n = 0;
                release_in_order();
            end
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && sent_flag) && pending_q.size() > 0
                && (calm || $urandom_range(99) >= 15))
            begin
                in_valid    <= 1'b1;
                action      <= pending_q[0].act;
                seq_number  <= pending_q[0].seq;
                payload_tag <= pending_q[0].tag;
            end
            else if (sent_flag || !in_valid)
                in_valid <= 1'b0;
            sent_flag = 1'b0;
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
        end
    end

    // accept and monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && !in_stall && !sent_flag)
        begin
            predict_reorder(pending_q.pop_front());
            n_sent++;
            sent_flag = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d seq=%0d tag=%0d grp=%0d last=%0d",
                         $time, out_kind, out_seq, out_tag, out_group, last_of_run);
                errors++;
            end
            else
            begin
                rel_t e;
                e = expected_q.pop_front();
                if (e.kind == KIND_DROP) n_drop++; else n_release++;
                if ({out_kind, out_seq, out_tag, out_group, last_of_run} !== e)
                begin
                    $display("%0t: mismatch expected kind=%0d seq=%0d tag=%0d grp=%0d last=%0d",
                             $time, e.kind, e.seq, e.tag, e.grp, e.last);
                    $display("%0t:          actual kind=%0d seq=%0d tag=%0d grp=%0d last=%0d",
                             $time, out_kind, out_seq, out_tag, out_group, last_of_run);
                    errors++;
                end
            end
        end
        if (cycles > 600000)
        begin
            $display("tb_heap_packet_reorder_buffer: FAIL");
            $finish;
        end
    end

    task automatic add(input logic a, input logic [15:0] s, input logic [15:0] t);
        pending_q.push_back({a, s, t});
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !in_valid);
        wait (expected_q.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_batch(input logic [6:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        batch_lim = v;
        if (batch_lim == 0) batch_lim = 1;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // shuffled window of consecutive numbers with random tags
    task automatic add_window(input int n);
        logic [15:0] w[$];
        int j;
        logic [15:0] t;
        for (int i = 0; i < n; i++) w.push_back(next_free + 16'(i));
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = w[i];
            w[i] = w[j];
            w[j] = t;
        end
        foreach (w[i]) add(ACT_PACKET, w[i], 16'($urandom));
        next_free = next_free + 16'(n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        seq_number = '0;
        payload_tag = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        n_release = 0;
        n_drop = 0;
        n_sent = 0;
        cycles = 0;
        calm = 1'b0;
        sent_flag = 1'b0;
        heap_n = 0;
        batch_n = 0;
        next_seq = '0;
        group_n = '0;
        batch_lim = 7'd1;
        next_free = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: end on empty heap, reorder, extremes
        add(ACT_END, 16'hffff, 16'hffff);
        add(ACT_PACKET, 16'd1, 16'hffff);
        add(ACT_PACKET, 16'd0, 16'h0000);
        add(ACT_PACKET, 16'd2, 16'h5555);
        add(ACT_PACKET, 16'd3, 16'haaaa);
        drain();
        next_free = next_seq;
        write_batch(7'd4);
        add(ACT_PACKET, next_free + 16'd1, 16'h0f0f);
        add(ACT_PACKET, next_free + 16'd2, 16'hf0f0);
        add(ACT_END, 16'h0, 16'h0);
        add(ACT_PACKET, next_free, 16'h8001);
        add(ACT_END, 16'h0, 16'h0);
        next_free = next_free + 16'd3;
        drain();
        // fill to full with no idling, overflow drops, then a 64-long run
        write_batch(7'd127);
        calm = 1'b1;
        for (int i = 0; i < 64; i++)
            add(ACT_PACKET, next_free + 16'd63 - 16'(i), 16'($urandom));
        add(ACT_PACKET, 16'hffff, 16'hffff);
        add(ACT_PACKET, 16'h8000, 16'h0001);
        add(ACT_END, 16'h0, 16'h0);
        next_free = next_free + 16'd64;
        drain();
        calm = 1'b0;
        write_batch(7'd0);
        add(ACT_PACKET, 16'hffff, 16'hffff);
        add(ACT_END, 16'h0, 16'h0);
        drain();
        next_free = next_seq;

        for (int ph = 0; ph < 4; ph++)
        begin
            write_batch(ph == 0 ? 7'd1 : ph == 1 ? 7'd64 : 7'($urandom_range(2, 9)));
            add_window($urandom_range(2, 6));
            if ($urandom_range(1) == 0)
                add(ACT_PACKET, 16'($urandom_range(40000, 65000)), 16'($urandom));
            add(ACT_END, 16'($urandom), 16'($urandom));
            drain();
            next_free = next_seq;
        end

        // stale duplicate at the root blocks every later release
        write_batch(7'd1);
        add(ACT_PACKET, next_free, 16'h0101);
        add(ACT_PACKET, next_free, 16'h0202);
        add(ACT_PACKET, next_free + 16'd1, 16'h0303);
        add(ACT_END, 16'h0, 16'h0);
        drain();

        $display("Covered %0d items: %0d in-order releases, %0d drops, final group %0d.",
                 n_sent, n_release, n_drop, group_n);
        $display("Batch sizes 0, 1, 4, 64, 127 and random; full heap, 64-long run and stale root.");
        if (errors == 0)
            $display("tb_heap_packet_reorder_buffer: PASS");
        else
            $display("tb_heap_packet_reorder_buffer: FAIL");
        $finish;
    end
endmodule
